/* rtl/rbsi_pkg.sv */
// Shared types and constants for the ray/box slab intersection block.
package rbsi_pkg;

  localparam int CW = 32;        // coordinate width, signed fixed point
  localparam int RW = CW + 1;    // divider remainder and numerator magnitude width

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BOX_MIN_X = 3'd0;
  localparam cfg_idx_t CFG_BOX_MIN_Y = 3'd1;
  localparam cfg_idx_t CFG_BOX_MIN_Z = 3'd2;
  localparam cfg_idx_t CFG_BOX_MAX_X = 3'd3;
  localparam cfg_idx_t CFG_BOX_MAX_Y = 3'd4;
  localparam cfg_idx_t CFG_BOX_MAX_Z = 3'd5;

  localparam coord_t POS_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t NEG_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
  } ray_t;

  typedef struct packed {
    logic   hit;
    coord_t t_near;
    coord_t t_far;
  } isect_t;

endpackage

/* rtl/rbsi_div_step.sv */
// One restoring division step: one quotient bit per register stage.
module rbsi_div_step
  import rbsi_pkg::*;
#(
  parameter int QW = 49,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QW-1:0] acc_i,
  input  logic [RW-1:0] rem_i,
  input  logic [CW-1:0] dmag_i,
  input  logic [TW-1:0] tag_i,
  output logic [QW-1:0] acc_o,
  output logic [RW-1:0] rem_o,
  output logic [CW-1:0] dmag_o,
  output logic [TW-1:0] tag_o
);

  logic [QW-1:0] acc_d, acc_q;
  logic [RW-1:0] rem_d, rem_q, r_sh;
  logic [CW-1:0] dmag_q;
  logic [TW-1:0] tag_q;
  logic          ge;

  // acc holds the numerator bits still to go at the top, quotient bits at the bottom
  always_comb begin
    r_sh  = {rem_i[RW-2:0], acc_i[QW-1]};
    ge    = (r_sh >= {1'b0, dmag_i});
    rem_d = ge ? (r_sh - {1'b0, dmag_i}) : r_sh;
    acc_d = {acc_i[QW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q  <= acc_d;
      rem_q  <= rem_d;
      dmag_q <= dmag_i;
      tag_q  <= tag_i;
    end
  end

  assign acc_o  = acc_q;
  assign rem_o  = rem_q;
  assign dmag_o = dmag_q;
  assign tag_o  = tag_q;

endmodule

/* rtl/rbsi_div.sv */
// Pipelined unsigned divider, QW stages, with a side tag carried alongside.
module rbsi_div
  import rbsi_pkg::*;
#(
  parameter int QW = 49,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QW-1:0] num_i,
  input  logic [CW-1:0] dmag_i,
  input  logic [TW-1:0] tag_i,
  output logic [QW-1:0] quot_o,
  output logic [TW-1:0] tag_o
);

  logic [QW-1:0] acc  [0:QW];
  logic [RW-1:0] rem  [0:QW];
  logic [CW-1:0] dmag [0:QW];
  logic [TW-1:0] tag  [0:QW];

  assign acc[0]  = num_i;
  assign rem[0]  = '0;
  assign dmag[0] = dmag_i;
  assign tag[0]  = tag_i;

  for (genvar s = 0; s < QW; s++) begin : g_step
    rbsi_div_step #(.QW(QW), .TW(TW)) u_step (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .acc_i  (acc[s]),
      .rem_i  (rem[s]),
      .dmag_i (dmag[s]),
      .tag_i  (tag[s]),
      .acc_o  (acc[s+1]),
      .rem_o  (rem[s+1]),
      .dmag_o (dmag[s+1]),
      .tag_o  (tag[s+1])
    );
  end

  assign quot_o = acc[QW];
  assign tag_o  = tag[QW];

endmodule

/* rtl/rbsi_reduce.sv */
// Saturation, per-axis ordering, near/far reduction and hit flag: four stages.
module rbsi_reduce
  import rbsi_pkg::*;
#(
  parameter int QW = 49
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [5:0][QW-1:0]  quot_i,
  input  logic [5:0]          neg_i,
  input  logic [2:0]          dz_i,
  input  logic [2:0]          ins_i,
  output isect_t              res_o
);

  localparam logic [QW-1:0] CAP = QW'(1) << (CW - 1);

  coord_t     sat_d [6];
  coord_t     sat_q [6];
  logic [2:0] dz_q, ins_q;
  coord_t     lo_d [3];
  coord_t     hi_d [3];
  coord_t     lo_q [3];
  coord_t     hi_q [3];
  coord_t     m01_lo, m01_hi, near_d, far_d, near_q, far_q;
  isect_t     res_q;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      if (neg_i[k]) begin
        sat_d[k] = (quot_i[k] > CAP) ? NEG_MIN : coord_t'(-quot_i[k][CW-1:0]);
      end else begin
        sat_d[k] = (quot_i[k] > CAP - QW'(1)) ? POS_MAX : coord_t'(quot_i[k][CW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) sat_q[k] <= sat_d[k];
      dz_q  <= dz_i;
      ins_q <= ins_i;
    end
  end

  // zero direction: unbounded inside the slab, empty interval outside
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (dz_q[a]) begin
        lo_d[a] = ins_q[a] ? NEG_MIN : POS_MAX;
        hi_d[a] = ins_q[a] ? POS_MAX : NEG_MIN;
      end else if (sat_q[a+3] < sat_q[a]) begin
        lo_d[a] = sat_q[a+3];
        hi_d[a] = sat_q[a];
      end else begin
        lo_d[a] = sat_q[a];
        hi_d[a] = sat_q[a+3];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= lo_d[a];
        hi_q[a] <= hi_d[a];
      end
    end
  end

  always_comb begin
    m01_lo = (lo_q[0] < lo_q[1]) ? lo_q[1] : lo_q[0];
    m01_hi = (hi_q[1] < hi_q[0]) ? hi_q[1] : hi_q[0];
    near_d = (m01_lo < lo_q[2]) ? lo_q[2] : m01_lo;
    far_d  = (hi_q[2] < m01_hi) ? hi_q[2] : m01_hi;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      near_q       <= near_d;
      far_q        <= far_d;
      res_q.hit    <= (near_q < far_q);
      res_q.t_near <= near_q;
      res_q.t_far  <= far_q;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/ray_box_slab_intersect.sv */
// Top level: ray versus axis-aligned box test, slab method, fully pipelined.
//
// Rays arrive on the in channel (in_valid_i/in_ready_o, in_data_i) as origin
// and direction in signed fixed point; one result (hit, t_near, t_far) leaves
// on the out channel (out_valid_o/out_ready_i, out_data_o) per ray, in order.
// The box corners sit in six registers written over the cfg channel
// (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i); cfg_ready_o is always
// high, indexes beyond the list are ignored. Write them only while idle.
// Path from transfer in to result valid (coordinates 32-bit Q16.16 by default):
// the input register loads at the transfer edge, then a prep stage, one stage
// per quotient bit in each of the six dividers, four reduce stages.
// Throughput: one ray per cycle while the output register is empty or
// out_ready_i is high, set by the pipelined one-bit-per-stage dividers.
// When the receiver stalls the whole pipeline holds and in_ready_o drops
// while the output register is full; nothing is lost or repeated.
// Reset clears all valid bits and loads the box to min 0.0, max 32.0.
module ray_box_slab_intersect
  import rbsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ray_t     in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output isect_t   out_data_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  cfg_idx_t cfg_index_i,
  input  coord_t   cfg_data_i
);

  localparam int     QW      = CW + 1 + FRAC_BITS;
  localparam int     NST     = QW + 6;
  localparam coord_t BOX_MAX = coord_t'(CW'(32) << FRAC_BITS);

  logic           en;
  logic [NST-1:0] vld_q;
  coord_t         box_q [6];
  ray_t           in_q;

  coord_t         o [3];
  coord_t         d [3];
  logic [QW-1:0]  num_d [6];
  logic [CW-1:0]  dmag_d [6];
  logic [5:0]     neg_d;
  logic [2:0]     dz_d, ins_d;
  logic [QW-1:0]  num_q [6];
  logic [CW-1:0]  dmag_q [6];
  logic [5:0]     neg_q;
  logic [2:0]     dz_q, ins_q;

  logic [5:0][QW-1:0] quot;
  logic [5:0]         neg_p;
  logic [2:0]         dz_p, ins_p;

  assign en          = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q[0] <= '0;
      box_q[1] <= '0;
      box_q[2] <= '0;
      box_q[3] <= BOX_MAX;
      box_q[4] <= BOX_MAX;
      box_q[5] <= BOX_MAX;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BOX_MIN_X: box_q[0] <= cfg_data_i;
        CFG_BOX_MIN_Y: box_q[1] <= cfg_data_i;
        CFG_BOX_MIN_Z: box_q[2] <= cfg_data_i;
        CFG_BOX_MAX_X: box_q[3] <= cfg_data_i;
        CFG_BOX_MAX_Y: box_q[4] <= cfg_data_i;
        CFG_BOX_MAX_Z: box_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) in_q <= in_data_i;
  end

  // prep: numerator magnitudes, divisor magnitudes, signs and slab flags
  always_comb begin
    o[0] = in_q.origin_x;
    o[1] = in_q.origin_y;
    o[2] = in_q.origin_z;
    d[0] = in_q.dir_x;
    d[1] = in_q.dir_y;
    d[2] = in_q.dir_z;
    for (int k = 0; k < 6; k++) begin
      logic [RW-1:0] bx, ox, nmag;
      logic          nneg;
      bx   = {box_q[k][CW-1], box_q[k]};
      ox   = {o[k%3][CW-1], o[k%3]};
      nneg = (box_q[k] < o[k%3]);
      nmag = nneg ? (ox - bx) : (bx - ox);
      num_d[k]  = {nmag, {FRAC_BITS{1'b0}}};
      dmag_d[k] = d[k%3][CW-1] ? (~d[k%3] + 1'b1) : d[k%3];
      neg_d[k]  = nneg ^ d[k%3][CW-1];
    end
    for (int a = 0; a < 3; a++) begin
      dz_d[a]  = (d[a] == '0);
      ins_d[a] = (box_q[a+3] < box_q[a])
               ? (o[a] >= box_q[a+3] && o[a] <= box_q[a])
               : (o[a] >= box_q[a] && o[a] <= box_q[a+3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        num_q[k]  <= num_d[k];
        dmag_q[k] <= dmag_d[k];
      end
      neg_q <= neg_d;
      dz_q  <= dz_d;
      ins_q <= ins_d;
    end
  end

  // min-plane dividers also carry the axis flags
  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_div #(.QW(QW), .TW(3)) u_div_min (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num_q[a]),
      .dmag_i (dmag_q[a]),
      .tag_i  ({dz_q[a], ins_q[a], neg_q[a]}),
      .quot_o (quot[a]),
      .tag_o  ({dz_p[a], ins_p[a], neg_p[a]})
    );
    rbsi_div #(.QW(QW), .TW(1)) u_div_max (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num_q[a+3]),
      .dmag_i (dmag_q[a+3]),
      .tag_i  (neg_q[a+3]),
      .quot_o (quot[a+3]),
      .tag_o  (neg_p[a+3])
    );
  end

  rbsi_reduce #(.QW(QW)) u_reduce (
    .clk_i  (clk_i),
    .en_i   (en),
    .quot_i (quot),
    .neg_i  (neg_p),
    .dz_i   (dz_p),
    .ins_i  (ins_p),
    .res_o  (out_data_o)
  );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the ray/box slab intersection block.
module testbench;
  import rbsi_pkg::*;

  localparam int FRAC  = 16;
  localparam int LAT   = 55 + 10;
  localparam int LIMIT = 600000;

  // Tracks the box corners, predicts each ray's result and holds the pending results.
  class isect_board;
    coord_t box[6];
    isect_t pending[$];
    int     errors;
    int     checked;
    int     hits;

    function new();
      box = '{0, 0, 0, 32 <<< FRAC, 32 <<< FRAC, 32 <<< FRAC};
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s got %h want %h", checked, what, got, want);
      errors++;
    endfunction

    // (plane - org) * 2^FRAC / d, truncated toward zero and saturated
    function coord_t slab_quot(coord_t plane, coord_t org, coord_t d);
      longint diff, dv;
      longint unsigned nmag, dmag, q;
      logic neg;
      diff = longint'(plane) - longint'(org);
      dv = longint'(d);
      if (diff == 0) return '0;
      nmag = diff < 0 ? -diff : diff;
      dmag = dv < 0 ? -dv : dv;
      neg = (diff < 0) != (dv < 0);
      q = (nmag << FRAC) / dmag;
      if (neg) return (q > 64'h8000_0000) ? NEG_MIN : coord_t'(-longint'(q));
      return (q > 64'h7fff_ffff) ? POS_MAX : coord_t'(q);
    endfunction

    function void note(ray_t r);
      coord_t org[3], dir[3];
      coord_t lo, hi, ta, tb, pl, ph, tn, tf;
      isect_t e;
      org = '{r.origin_x, r.origin_y, r.origin_z};
      dir = '{r.dir_x, r.dir_y, r.dir_z};
      tn = NEG_MIN;
      tf = POS_MAX;
      for (int ax = 0; ax < 3; ax++) begin
        if (dir[ax] == 0) begin
          pl = (box[ax+3] < box[ax]) ? box[ax+3] : box[ax];
          ph = (box[ax+3] < box[ax]) ? box[ax] : box[ax+3];
          if (org[ax] >= pl && org[ax] <= ph) begin
            lo = NEG_MIN; hi = POS_MAX;
          end else begin
            lo = POS_MAX; hi = NEG_MIN;
          end
        end else begin
          ta = slab_quot(box[ax], org[ax], dir[ax]);
          tb = slab_quot(box[ax+3], org[ax], dir[ax]);
          lo = (tb < ta) ? tb : ta;
          hi = (tb < ta) ? ta : tb;
        end
        if (tn < lo) tn = lo;
        if (hi < tf) tf = hi;
      end
      e.hit = tn < tf;
      e.t_near = tn;
      e.t_far = tf;
      pending.push_back(e);
    endfunction

    function void check(isect_t got);
      isect_t w;
      if (pending.size() == 0) begin
        $display("result with no ray outstanding: %h", got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.hit !== w.hit) report("hit", got.hit, w.hit);
      if (got.t_near !== w.t_near) report("t_near", got.t_near, w.t_near);
      if (got.t_far !== w.t_far) report("t_far", got.t_far, w.t_far);
      hits += w.hit;
      checked++;
    endfunction
  endclass

  logic     clk_i = 0;
  logic     rst_ni = 0;
  logic     in_valid_i = 0;
  logic     in_ready_o;
  ray_t     in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 0;
  isect_t   out_data_o;
  logic     cfg_valid_i = 0;
  logic     cfg_ready_o;
  cfg_idx_t cfg_index_i = CFG_BOX_MIN_X;
  coord_t   cfg_data_i = '0;

  isect_board board = new();
  int  cycles = 0;
  bit  no_idle = 0;
  bit  hold_req = 0;
  int  rays_sent = 0;

  ray_box_slab_intersect dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) board.note(in_data_i);
    if (out_valid_o && out_ready_i) board.check(out_data_o);
    if (cfg_valid_i && cfg_ready_o && cfg_index_i < 6) board.box[cfg_index_i] = cfg_data_i;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** ray_box_slab_intersect: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off when asked
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready_i <= 0;
        repeat (400) @(posedge clk_i);
      end
      n = no_idle ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_ready_i <= 0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_ray(ray_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    rays_sent++;
  endtask

  // leaves the channel valid so that writes can follow back to back
  task automatic write_box(cfg_idx_t idx, coord_t v);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LAT) @(posedge clk_i);
  endtask

  function automatic coord_t near_coord();
    return coord_t'(int'($urandom_range(0, 112 << FRAC)) - (40 << FRAC));
  endfunction

  function automatic coord_t rand_dir();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return coord_t'($urandom);
      2: return coord_t'(int'($urandom_range(0, 64)) - 32);
      default: return coord_t'(int'($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    if ($urandom_range(0, 9) == 0) return ray_t'({$urandom, $urandom, $urandom,
                                                  $urandom, $urandom, $urandom});
    r.origin_x = near_coord(); r.origin_y = near_coord(); r.origin_z = near_coord();
    r.dir_x = rand_dir(); r.dir_y = rand_dir(); r.dir_z = rand_dir();
    return r;
  endfunction

  function automatic ray_t mk(coord_t ox, coord_t oy, coord_t oz,
                              coord_t dx, coord_t dy, coord_t dz);
    ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    return r;
  endfunction

  initial begin
    localparam coord_t ONE = 1 <<< FRAC;
    ray_t dl[$];
    coord_t a, b;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed rays against the reset box
    dl.push_back(mk(-ONE, ONE, ONE, ONE, 0, 0));              // zero dirs, inside slabs
    dl.push_back(mk(-ONE, -ONE, ONE, ONE, 0, 0));             // zero dir outside slab
    dl.push_back(mk(0, 0, 0, 0, 0, 0));                        // on plane, all zero
    dl.push_back(mk(32 * ONE, 32 * ONE, 32 * ONE, 0, 0, 0));  // upper planes inclusive
    dl.push_back(mk(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    dl.push_back(mk(40 * ONE, 40 * ONE, 40 * ONE, -ONE, -ONE, -ONE));
    dl.push_back(mk(ONE, ONE, ONE, 1, 1, 1));                  // quotients saturate
    dl.push_back(mk(ONE, ONE, ONE, -1, -1, -1));
    dl.push_back(mk(NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN));
    dl.push_back(mk(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX));
    dl.push_back(mk(NEG_MIN, POS_MAX, 0, POS_MAX, NEG_MIN, 1));
    dl.push_back(mk(POS_MAX, NEG_MIN, -1, -1, 1, NEG_MIN));
    dl.push_back(mk(-1, -1, -1, '1, '1, '1));
    dl.push_back(mk(ONE, ONE, ONE, ONE, 0, ONE));
    dl.push_back(mk(-ONE, 16 * ONE, 16 * ONE, 2 * ONE, 0, 0));
    dl.push_back(mk(-ONE, 40 * ONE, 16 * ONE, ONE, ONE, 0)); // miss, tie region
    dl.push_back(mk(16 * ONE, 16 * ONE, 16 * ONE, 3, -7, 11));
    no_idle = 1;
    foreach (dl[i]) send_ray(dl[i]);
    no_idle = 0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: for (int i = 0; i < 3; i++) begin               // random small box
          a = near_coord(); b = near_coord();
          write_box(cfg_idx_t'(i), (a < b) ? a : b);
          write_box(cfg_idx_t'(i + 3), (a < b) ? b : a);
        end
        2: for (int i = 0; i < 3; i++) begin               // inverted box
          write_box(cfg_idx_t'(i), 20 * ONE);
          write_box(cfg_idx_t'(i + 3), -4 * ONE);
        end
        3: for (int i = 0; i < 3; i++) begin               // extreme corners
          write_box(cfg_idx_t'(i), NEG_MIN);
          write_box(cfg_idx_t'(i + 3), POS_MAX);
        end
        4: for (int i = 0; i < 3; i++) begin               // flat box
          a = near_coord();
          write_box(cfg_idx_t'(i), a);
          write_box(cfg_idx_t'(i + 3), a);
        end
        5: for (int i = 0; i < 6; i++) write_box(cfg_idx_t'(i), coord_t'($urandom));
        default: ;
      endcase
      cfg_valid_i <= 0;
      for (int n = 0; n < 265; n++) begin
        no_idle = (n >= 100 && n < 140);
        if (ph == 2 && n == 150) hold_req = 1;
        send_ray(rand_ray());
      end
      no_idle = 0;
      drain();
    end

    $display("%0d rays sent over six box settings, %0d results checked, %0d hits",
             rays_sent, board.checked, board.hits);
    if (board.pending.size() != 0) begin
      $display("%0d results never arrived", board.pending.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("** ray_box_slab_intersect: PASSED **");
    end else begin
      $display("** ray_box_slab_intersect: FAILED **");
    end
    $finish;
  end

endmodule

/* ray_box_slab_intersect.f */
rtl/rbsi_pkg.sv
rtl/rbsi_div_step.sv
rtl/rbsi_div.sv
rtl/rbsi_reduce.sv
rtl/ray_box_slab_intersect.sv
verif/testbench.sv
